[rtl/drgr_pkg.sv]
// Shared constants and types for the distance-grid resampler.
package drgr_pkg;

	localparam int DIST_W    = 32;
	localparam int STEP_W    = 16;
	localparam int NUM_W     = DIST_W + 1;
	localparam int DIV_CNT_W = 6;

	localparam int MAX_RUN_DEF   = 64;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd1000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic fbit;
	} lerp_ctl_t;

endpackage

[rtl/drgr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module drgr_div
	import drgr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_CNT_W-1:0] steps,
	input  logic [NUM_W-1:0]     num,
	input  logic [DIST_W-1:0]    rem_init,
	input  logic [DIST_W-1:0]    divisor,
	output logic                 done,
	output logic [NUM_W-1:0]     quo,
	output logic [DIST_W-1:0]    rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIST_W-1:0]    rem_q;
	logic [DIST_W-1:0]    div_q;
	logic [NUM_W-1:0]     num_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DIST_W:0]      trial;
	logic [DIST_W:0]      diff;
	logic                 fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			div_q <= divisor;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/drgr_lerp.sv]
// Bit-serial interpolation lane: lo + floor(frac * (hi - lo) / 2^F).
module drgr_lerp
	import drgr_pkg::*;
#(
	parameter int W         = 16,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  lerp_ctl_t    ctl,
	input  logic [W-1:0] lo,
	input  logic [W-1:0] hi,
	output logic [W-1:0] res
);

	logic signed [W:0]   diff;
	logic signed [W+1:0] sum;
	logic [W+1:0]        h_q;
	logic [FRAC_BITS:0]  l_q;

	assign diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign sum  = $signed(h_q) + (ctl.fbit ? (W+2)'(diff) : (W+2)'(0));

	// shift-and-add, frac taken LSB first, product lands in {h_q, l_q}
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			h_q <= '0;
			l_q <= '0;
		end else if (ctl.step) begin
			h_q <= {sum[W+1], sum[W+1:1]};
			l_q <= {sum[0], l_q[FRAC_BITS:1]};
		end
	end

	assign res = lo + {h_q[W-2:0], l_q[FRAC_BITS]};

endmodule

[rtl/distance_grid_linear_resampler.sv]
// Top level of the distance-grid linear resampler.
//
//  channel   signals                                   direction  width
//  item      item_valid/item_ready, distance..last     in         sample word
//  result    res_valid/res_ready, out_distance..       out        result word
//  config    step_we, step_wdata                       in         16
//
// An item is taken in S_IDLE and checked in S_CHECK the cycle after; with grid
// points it then counts them in S_NDIV (serial 33-bit divide by step).
// Each point passes S_POINT (setup), S_FDIV (serial fraction divide), S_MUL
// (serial multiply lanes) and S_EMIT; a point on the sample's own distance
// skips the divide. Reset clears control, step 1000.
// A stalled result word holds in the output register; an emit state waits for it.
module distance_grid_linear_resampler
	import drgr_pkg::*;
#(
	parameter int MAX_RUN   = MAX_RUN_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_we,
	input  logic [15:0] step_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] distance,
	input  logic [31:0] time_us,
	input  logic [15:0] speed,
	input  logic [15:0] throttle,
	input  logic [15:0] brake,
	input  logic [3:0]  gear,
	input  logic [15:0] rpm,
	input  logic [7:0]  drs,
	input  logic        last_sample,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] out_distance,
	output logic [31:0] out_time_us,
	output logic [15:0] out_speed,
	output logic [15:0] out_throttle,
	output logic [15:0] out_brake,
	output logic [3:0]  out_gear,
	output logic [15:0] out_rpm,
	output logic [7:0]  out_drs,
	output logic [1:0]  status,
	output logic        run_end,
	output logic        stream_end
);

	localparam int RUN_W  = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
	localparam int MCNT_W = $clog2(FRAC_BITS + 2);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_NDIV, S_POINT, S_FDIV, S_MUL, S_EMIT, S_PASS, S_ERR
	} state_t;

	state_t state_q;

	logic [STEP_W-1:0] step_q;
	logic              active_q;
	logic              trunc_q;
	logic [NUM_W-1:0]  ng_q;
	logic [NUM_W-1:0]  ng_after_q;
	logic [NUM_W-1:0]  g_q;
	logic [RUN_W-1:0]  emit_left_q;
	logic [FRAC_BITS:0] frac_q;
	logic [MCNT_W-1:0] mcnt_q;

	// current (upper) sample and previous (lower) sample
	logic [31:0] cur_d_q, cur_t_q, prev_d_q, prev_t_q;
	logic [15:0] cur_sp_q, cur_th_q, cur_br_q, cur_rp_q;
	logic [15:0] prev_sp_q, prev_th_q, prev_br_q, prev_rp_q;
	logic [3:0]  cur_ge_q, prev_ge_q;
	logic [7:0]  cur_dr_q, prev_dr_q;
	logic        cur_last_q;

	logic        res_valid_q;
	logic [31:0] out_d_q, out_t_q;
	logic [15:0] out_sp_q, out_th_q, out_br_q, out_rp_q;
	logic [3:0]  out_ge_q;
	logic [7:0]  out_dr_q;
	logic [1:0]  status_q;
	logic        run_end_q, stream_end_q;

	logic [STEP_W-1:0] step_eff;
	logic              slot_free;
	logic              res_load;
	logic              order_err;
	logic              has_pts;
	logic              at_hi;
	logic [NUM_W-1:0]  n_num;
	logic [1:0]        run_status;

	logic                 div_start;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [NUM_W-1:0]     div_num;
	logic [DIST_W-1:0]    div_rem_init;
	logic [DIST_W-1:0]    div_divisor;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quo;
	logic [DIST_W-1:0]    div_rem;

	lerp_ctl_t   lctl;
	logic [31:0] l_time;
	logic [15:0] l_speed, l_throttle, l_brake, l_rpm;

	assign step_eff   = (step_q == '0) ? STEP_W'(1) : step_q;
	assign slot_free  = !res_valid_q || res_ready;
	// a new result word goes into the output register this cycle
	assign res_load   = slot_free &&
	                    (state_q == S_EMIT || state_q == S_PASS || state_q == S_ERR);
	assign order_err  = cur_d_q <= prev_d_q;
	assign at_hi      = g_q == {1'b0, cur_d_q};
	assign run_status = trunc_q ? ST_TRUNC : ST_OK;
	// on the last sample the point at its own distance is left out
	assign has_pts    = cur_last_q ? (ng_q < {1'b0, cur_d_q}) : (ng_q <= {1'b0, cur_d_q});
	assign n_num      = cur_last_q ? ({1'b0, cur_d_q} - NUM_W'(1) - ng_q)
	                               : ({1'b0, cur_d_q} - ng_q);

	// one divider serves the grid count and each point's fraction
	always_comb begin
		div_start    = 1'b0;
		div_steps    = DIV_CNT_W'(FRAC_BITS);
		div_num      = '0;
		div_rem_init = g_q[DIST_W-1:0] - prev_d_q;
		div_divisor  = cur_d_q - prev_d_q;
		if (state_q == S_CHECK) begin
			div_start    = active_q && !order_err && has_pts;
			div_steps    = DIV_CNT_W'(NUM_W);
			div_num      = n_num;
			div_rem_init = '0;
			div_divisor  = {{(DIST_W-STEP_W){1'b0}}, step_eff};
		end else if (state_q == S_POINT) begin
			div_start = !at_hi;
		end
	end

	drgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.num      (div_num),
		.rem_init (div_rem_init),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign lctl.load = (state_q == S_POINT && at_hi) || (state_q == S_FDIV && div_done);
	assign lctl.step = state_q == S_MUL;
	assign lctl.fbit = frac_q[0];

	drgr_lerp #(.W(32), .FRAC_BITS(FRAC_BITS)) u_time (
		.clk(clk), .ctl(lctl), .lo(prev_t_q), .hi(cur_t_q), .res(l_time));
	drgr_lerp #(.W(16), .FRAC_BITS(FRAC_BITS)) u_speed (
		.clk(clk), .ctl(lctl), .lo(prev_sp_q), .hi(cur_sp_q), .res(l_speed));
	drgr_lerp #(.W(16), .FRAC_BITS(FRAC_BITS)) u_throttle (
		.clk(clk), .ctl(lctl), .lo(prev_th_q), .hi(cur_th_q), .res(l_throttle));
	drgr_lerp #(.W(16), .FRAC_BITS(FRAC_BITS)) u_brake (
		.clk(clk), .ctl(lctl), .lo(prev_br_q), .hi(cur_br_q), .res(l_brake));
	drgr_lerp #(.W(16), .FRAC_BITS(FRAC_BITS)) u_rpm (
		.clk(clk), .ctl(lctl), .lo(prev_rp_q), .hi(cur_rp_q), .res(l_rpm));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= STEP_RESET;
			active_q     <= 1'b0;
			trunc_q      <= 1'b0;
			ng_q         <= '0;
			ng_after_q   <= '0;
			g_q          <= '0;
			emit_left_q  <= '0;
			frac_q       <= '0;
			mcnt_q       <= '0;
			cur_d_q      <= '0; cur_t_q  <= '0; cur_sp_q <= '0; cur_th_q <= '0;
			cur_br_q     <= '0; cur_ge_q <= '0; cur_rp_q <= '0; cur_dr_q <= '0;
			cur_last_q   <= 1'b0;
			prev_d_q     <= '0; prev_t_q  <= '0; prev_sp_q <= '0; prev_th_q <= '0;
			prev_br_q    <= '0; prev_ge_q <= '0; prev_rp_q <= '0; prev_dr_q <= '0;
			res_valid_q  <= 1'b0;
			out_d_q      <= '0; out_t_q  <= '0; out_sp_q <= '0; out_th_q <= '0;
			out_br_q     <= '0; out_ge_q <= '0; out_rp_q <= '0; out_dr_q <= '0;
			status_q     <= ST_OK;
			run_end_q    <= 1'b0;
			stream_end_q <= 1'b0;
		end else begin
			if (step_we) begin
				step_q <= step_wdata;
			end
			// drop the output word once taken, unless a new one loads now
			if (res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cur_d_q    <= distance;
						cur_t_q    <= time_us;
						cur_sp_q   <= speed;
						cur_th_q   <= throttle;
						cur_br_q   <= brake;
						cur_ge_q   <= gear;
						cur_rp_q   <= rpm;
						cur_dr_q   <= drs;
						cur_last_q <= last_sample;
						state_q    <= S_CHECK;
					end
				end

				S_CHECK: begin
					trunc_q <= 1'b0;
					if (!active_q) begin
						// first sample: becomes the lower sample and grid origin
						prev_d_q  <= cur_d_q;  prev_t_q  <= cur_t_q;
						prev_sp_q <= cur_sp_q; prev_th_q <= cur_th_q;
						prev_br_q <= cur_br_q; prev_ge_q <= cur_ge_q;
						prev_rp_q <= cur_rp_q; prev_dr_q <= cur_dr_q;
						ng_q      <= {1'b0, cur_d_q};
						if (cur_last_q) begin
							state_q <= S_PASS;
						end else begin
							active_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (order_err) begin
						state_q <= S_ERR;
					end else if (has_pts) begin
						state_q <= S_NDIV;
					end else if (cur_last_q) begin
						state_q <= S_PASS;
					end else begin
						prev_d_q  <= cur_d_q;  prev_t_q  <= cur_t_q;
						prev_sp_q <= cur_sp_q; prev_th_q <= cur_th_q;
						prev_br_q <= cur_br_q; prev_ge_q <= cur_ge_q;
						prev_rp_q <= cur_rp_q; prev_dr_q <= cur_dr_q;
						state_q   <= S_IDLE;
					end
				end

				S_NDIV: begin
					if (div_done) begin
						// quotient is the point count minus one
						if (div_quo >= NUM_W'(MAX_RUN - 1)) begin
							trunc_q     <= 1'b1;
							emit_left_q <= RUN_W'(MAX_RUN - 1);
						end else begin
							emit_left_q <= div_quo[RUN_W-1:0] + 1'b1;
						end
						// first grid point past this sample
						ng_after_q <= {1'b0, cur_d_q} - NUM_W'(div_rem[STEP_W-1:0])
						              + NUM_W'(step_eff);
						g_q        <= ng_q;
						state_q    <= S_POINT;
					end
				end

				S_POINT: begin
					if (at_hi) begin
						frac_q  <= (FRAC_BITS+1)'(1) << FRAC_BITS;
						mcnt_q  <= MCNT_W'(FRAC_BITS + 1);
						state_q <= S_MUL;
					end else begin
						state_q <= S_FDIV;
					end
				end

				S_FDIV: begin
					if (div_done) begin
						frac_q  <= {1'b0, div_quo[FRAC_BITS-1:0]};
						mcnt_q  <= MCNT_W'(FRAC_BITS + 1);
						state_q <= S_MUL;
					end
				end

				S_MUL: begin
					frac_q <= frac_q >> 1;
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == MCNT_W'(1)) begin
						state_q <= S_EMIT;
					end
				end

				S_EMIT: begin
					if (slot_free) begin
						res_valid_q  <= 1'b1;
						out_d_q      <= g_q[DIST_W-1:0];
						out_t_q      <= l_time;
						out_sp_q     <= l_speed;
						out_th_q     <= l_throttle;
						out_br_q     <= l_brake;
						out_rp_q     <= l_rpm;
						out_ge_q     <= at_hi ? cur_ge_q : prev_ge_q;
						out_dr_q     <= at_hi ? cur_dr_q : prev_dr_q;
						status_q     <= run_status;
						run_end_q    <= (emit_left_q == RUN_W'(1)) && !cur_last_q;
						stream_end_q <= 1'b0;
						emit_left_q  <= emit_left_q - 1'b1;
						g_q          <= g_q + NUM_W'(step_eff);
						if (emit_left_q != RUN_W'(1)) begin
							state_q <= S_POINT;
						end else if (cur_last_q) begin
							state_q <= S_PASS;
						end else begin
							prev_d_q  <= cur_d_q;  prev_t_q  <= cur_t_q;
							prev_sp_q <= cur_sp_q; prev_th_q <= cur_th_q;
							prev_br_q <= cur_br_q; prev_ge_q <= cur_ge_q;
							prev_rp_q <= cur_rp_q; prev_dr_q <= cur_dr_q;
							ng_q      <= ng_after_q;
							state_q   <= S_IDLE;
						end
					end
				end

				S_PASS: begin
					// hand the final sample through unchanged, end the stream
					if (slot_free) begin
						res_valid_q  <= 1'b1;
						out_d_q      <= cur_d_q;
						out_t_q      <= cur_t_q;
						out_sp_q     <= cur_sp_q;
						out_th_q     <= cur_th_q;
						out_br_q     <= cur_br_q;
						out_rp_q     <= cur_rp_q;
						out_ge_q     <= cur_ge_q;
						out_dr_q     <= cur_dr_q;
						status_q     <= run_status;
						run_end_q    <= 1'b1;
						stream_end_q <= 1'b1;
						active_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				S_ERR: begin
					// report and drop the out-of-order sample
					if (slot_free) begin
						res_valid_q  <= 1'b1;
						out_d_q      <= '0;
						out_t_q      <= '0;
						out_sp_q     <= '0;
						out_th_q     <= '0;
						out_br_q     <= '0;
						out_rp_q     <= '0;
						out_ge_q     <= '0;
						out_dr_q     <= '0;
						status_q     <= ST_ORDER;
						run_end_q    <= 1'b1;
						stream_end_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready   = state_q == S_IDLE;
	assign res_valid    = res_valid_q;
	assign out_distance = out_d_q;
	assign out_time_us  = out_t_q;
	assign out_speed    = out_sp_q;
	assign out_throttle = out_th_q;
	assign out_brake    = out_br_q;
	assign out_gear     = out_ge_q;
	assign out_rpm      = out_rp_q;
	assign out_drs      = out_dr_q;
	assign status       = status_q;
	assign run_end      = run_end_q;
	assign stream_end   = stream_end_q;

`ifndef SYNTH
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_ORDER) |-> (run_end && !stream_end))
		else $error("order error word malformed");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT || state_q == S_MUL) |-> (emit_left_q != '0))
		else $error("point emitted with empty run count");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_NDIV || state_q == S_FDIV))
		else $error("divider finished outside a divide state");

	a_stream_close: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid) && stream_end) |-> !active_q)
		else $error("stream end word while still active");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the distance-grid linear resampler.
`timescale 1ns / 1ps

module testbench;
	import drgr_pkg::*;

	// One telemetry sample as offered on the item channel.
	typedef struct packed {
		logic [31:0] distance;
		logic [31:0] time_us;
		logic [15:0] speed;
		logic [15:0] throttle;
		logic [15:0] brake;
		logic [3:0]  gear;
		logic [15:0] rpm;
		logic [7:0]  drs;
		logic        last_sample;
	} sample_t;

	// One resampled point as seen on the result channel.
	typedef struct packed {
		logic [31:0] distance;
		logic [31:0] time_us;
		logic [15:0] speed;
		logic [15:0] throttle;
		logic [15:0] brake;
		logic [3:0]  gear;
		logic [15:0] rpm;
		logic [7:0]  drs;
		logic [1:0]  status;
		logic        run_end;
		logic        stream_end;
	} point_t;

	// How a directed row gets its expected words.
	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_PASS,
		EXP_ORDER
	} row_kind_t;

	typedef struct {
		sample_t   smp;
		row_kind_t kind;
	} dir_row_t;

	localparam int FRAC   = FRAC_BITS_DEF;
	localparam int RUN    = MAX_RUN_DEF;
	localparam int SETTLE = 150;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        step_we;
	logic [15:0] step_wdata;
	logic        item_valid;
	logic        item_ready;
	logic [31:0] distance;
	logic [31:0] time_us;
	logic [15:0] speed;
	logic [15:0] throttle;
	logic [15:0] brake;
	logic [3:0]  gear;
	logic [15:0] rpm;
	logic [7:0]  drs;
	logic        last_sample;
	logic        res_valid;
	logic        res_ready;
	logic [31:0] out_distance;
	logic [31:0] out_time_us;
	logic [15:0] out_speed;
	logic [15:0] out_throttle;
	logic [15:0] out_brake;
	logic [3:0]  out_gear;
	logic [15:0] out_rpm;
	logic [7:0]  out_drs;
	logic [1:0]  status;
	logic        run_end;
	logic        stream_end;

	distance_grid_linear_resampler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_we     (step_we),
		.step_wdata  (step_wdata),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.distance    (distance),
		.time_us     (time_us),
		.speed       (speed),
		.throttle    (throttle),
		.brake       (brake),
		.gear        (gear),
		.rpm         (rpm),
		.drs         (drs),
		.last_sample (last_sample),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_distance(out_distance),
		.out_time_us (out_time_us),
		.out_speed   (out_speed),
		.out_throttle(out_throttle),
		.out_brake   (out_brake),
		.out_gear    (out_gear),
		.out_rpm     (out_rpm),
		.out_drs     (out_drs),
		.status      (status),
		.run_end     (run_end),
		.stream_end  (stream_end)
	);

	// Predictor state: mirrors the block's lower sample and grid position.
	logic [15:0]     grid_step;
	bit              stream_open;
	longint unsigned grid_next;
	sample_t         lower;

	point_t   pending_points[$];
	dir_row_t dir_tab[$];
	int       fail_cnt;
	bit       quiet;
	bit       pressure_req;
	int       idle_cycles;

	always #5 clk = ~clk;

	// Linear blend with the floor taken toward minus infinity.
	function automatic longint unsigned blend(longint unsigned lo, longint unsigned hi,
		longint unsigned frac);
		longint unsigned mask;
		mask = (64'd1 << FRAC) - 1;
		if (hi >= lo)
			return lo + ((frac * (hi - lo)) >> FRAC);
		return lo - (((frac * (lo - hi)) + mask) >> FRAC);
	endfunction

	// Work out every point one accepted sample causes, and advance the state.
	function automatic void grid_predict(sample_t s, ref point_t words[$]);
		point_t          p;
		longint unsigned stp, n, emit, g, frac, span;
		bit              trunc;
		words.delete();
		if (!stream_open) begin
			lower     = s;
			grid_next = s.distance;
			if (s.last_sample) begin
				p = '{s.distance, s.time_us, s.speed, s.throttle, s.brake, s.gear,
					s.rpm, s.drs, ST_OK, 1'b1, 1'b1};
				words.insert(words.size(), p);
			end else begin
				stream_open = 1;
			end
			return;
		end
		// Drop a sample that does not move forward; state stays put.
		if (s.distance <= lower.distance) begin
			p = '0;
			p.status  = ST_ORDER;
			p.run_end = 1'b1;
			words.insert(words.size(), p);
			return;
		end
		stp = (grid_step == 0) ? 1 : grid_step;
		n   = 0;
		if (s.last_sample) begin
			if (grid_next < s.distance)
				n = (longint'(s.distance) - 1 - grid_next) / stp + 1;
		end else if (grid_next <= s.distance) begin
			n = (longint'(s.distance) - grid_next) / stp + 1;
		end
		emit  = (n < RUN - 1) ? n : RUN - 1;
		trunc = n > emit;
		span  = longint'(s.distance) - lower.distance;
		for (longint unsigned i = 0; i < emit; i++) begin
			g    = grid_next + i * stp;
			frac = ((g - lower.distance) << FRAC) / span;
			p.distance   = g[31:0];
			p.time_us    = 32'(blend(lower.time_us, s.time_us, frac));
			p.speed      = 16'(blend(lower.speed, s.speed, frac));
			p.throttle   = 16'(blend(lower.throttle, s.throttle, frac));
			p.brake      = 16'(blend(lower.brake, s.brake, frac));
			p.gear       = (g == s.distance) ? s.gear : lower.gear;
			p.rpm        = 16'(blend(lower.rpm, s.rpm, frac));
			p.drs        = (g == s.distance) ? s.drs : lower.drs;
			p.status     = trunc ? ST_TRUNC : ST_OK;
			p.run_end    = 1'b0;
			p.stream_end = 1'b0;
			words.insert(words.size(), p);
		end
		grid_next += n * stp;
		if (s.last_sample) begin
			p = '{s.distance, s.time_us, s.speed, s.throttle, s.brake, s.gear,
				s.rpm, s.drs, trunc ? ST_TRUNC : ST_OK, 1'b0, 1'b1};
			words.insert(words.size(), p);
			stream_open = 0;
		end else begin
			lower = s;
		end
		if (words.size() > 0)
			words[words.size()-1].run_end = 1'b1;
	endfunction

	function automatic void add_row(logic [31:0] d, logic [31:0] t, logic [15:0] sp,
		logic [15:0] th, logic [15:0] br, logic [3:0] ge, logic [15:0] rp, logic [7:0] dr,
		logic lst, row_kind_t kind);
		dir_row_t r;
		r.smp  = '{d, t, sp, th, br, ge, rp, dr, lst};
		r.kind = kind;
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	function automatic void check_field(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fail_cnt++;
		end
	endfunction

	// Offer one word, hold it until accepted, then queue what it should cause.
	task automatic send_word(sample_t s, row_kind_t kind);
		point_t words[$];
		point_t p;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		distance    <= s.distance;
		time_us     <= s.time_us;
		speed       <= s.speed;
		throttle    <= s.throttle;
		brake       <= s.brake;
		gear        <= s.gear;
		rpm         <= s.rpm;
		drs         <= s.drs;
		last_sample <= s.last_sample;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		grid_predict(s, words);
		// Typed-in expectations replace the predicted words for simple rows.
		if (kind == EXP_PASS) begin
			p = '{s.distance, s.time_us, s.speed, s.throttle, s.brake, s.gear,
				s.rpm, s.drs, ST_OK, 1'b1, 1'b1};
			words.delete();
			words.insert(0, p);
		end else if (kind == EXP_ORDER) begin
			p = '0;
			p.status  = ST_ORDER;
			p.run_end = 1'b1;
			words.delete();
			words.insert(0, p);
		end
		foreach (words[i]) pending_points.insert(pending_points.size(), words[i]);
	endtask

	// Drain, let any point-free work finish, then write the grid step.
	task automatic write_step(logic [15:0] v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		step_we    <= 1'b1;
		step_wdata <= v;
		@(posedge clk);
		step_we   <= 1'b0;
		grid_step = v;
	endtask

	// Random streams: mostly well-formed runs, some backward noise and big gaps.
	task automatic random_streams(int count);
		sample_t         s;
		longint unsigned stp, nxt;
		logic [31:0]     cur_d;
		int              left, len, pick;
		bit              open;
		left = count;
		open = 0;
		stp  = (grid_step == 0) ? 1 : grid_step;
		while (left > 0) begin
			if (!open) begin
				len   = $urandom_range(1, 10);
				cur_d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h8000_0000);
				open  = 1;
				s.distance = cur_d;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					s.distance = cur_d - $urandom_range(0, 3000);
				end else begin
					if (pick < 15)
						nxt = longint'(cur_d) + stp * $urandom_range(64, 90) + $urandom_range(0, 5);
					else
						nxt = longint'(cur_d) + stp * $urandom_range(0, 4) + $urandom_range(1, stp);
					if (nxt > 64'hFFFF_FFFF) begin
						nxt = 64'hFFFF_FFFF;
						len = 1;
					end
					s.distance = nxt[31:0];
					cur_d      = nxt[31:0];
				end
			end
			len--;
			s.time_us     = $urandom;
			s.speed       = 16'($urandom);
			s.throttle    = 16'($urandom);
			s.brake       = 16'($urandom);
			s.gear        = 4'($urandom);
			s.rpm         = 16'($urandom);
			s.drs         = 8'($urandom);
			s.last_sample = (len <= 0);
			if (s.last_sample) open = 0;
			if (cur_d == 32'hFFFF_FFFF && !s.last_sample) begin
				s.last_sample = 1'b1;
				open = 0;
			end
			send_word(s, EXP_MODEL);
			left--;
		end
	endtask

	// Check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		point_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_points.size() == 0) begin
				$error("result word with no expectation, distance %0h", out_distance);
				fail_cnt++;
			end else begin
				e = pending_points.pop_front();
				check_field("out_distance", e.distance, out_distance);
				check_field("out_time_us", e.time_us, out_time_us);
				check_field("out_speed", e.speed, out_speed);
				check_field("out_throttle", e.throttle, out_throttle);
				check_field("out_brake", e.brake, out_brake);
				check_field("out_gear", e.gear, out_gear);
				check_field("out_rpm", e.rpm, out_rpm);
				check_field("out_drs", e.drs, out_drs);
				check_field("status", e.status, status);
				check_field("run_end", e.run_end, run_end);
				check_field("stream_end", e.stream_end, stream_end);
			end
		end
	end

	// Count cycles with no accepted word on either channel.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random ready bursts, one long hold-off, none at the end.
	initial begin
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				res_ready <= 1'b1;
				@(posedge clk);
			end else if (pressure_req) begin
				// Hold off long enough for the block to back up its input.
				res_ready <= 1'b0;
				repeat (600) @(posedge clk);
				pressure_req = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [15:0] phase_step[5];
		clk          = 1'b0;
		arst_n       = 1'b0;
		step_we      = 1'b0;
		step_wdata   = '0;
		item_valid   = 1'b0;
		distance     = '0;
		time_us      = '0;
		speed        = '0;
		throttle     = '0;
		brake        = '0;
		gear         = '0;
		rpm          = '0;
		drs          = '0;
		last_sample  = 1'b0;
		res_ready    = 1'b0;
		fail_cnt     = 0;
		quiet        = 0;
		pressure_req = 0;
		idle_cycles  = 0;
		grid_step    = STEP_RESET;
		stream_open  = 0;
		grid_next    = 0;
		lower        = '0;

		// Single-sample streams pass through at both field extremes.
		add_row(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0, 8'h0, 1'b1, EXP_PASS);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF,
			8'hFF, 1'b1, EXP_PASS);
		// Open a stream; repeated and backward distances are dropped.
		add_row(32'd1000, 32'd100, 16'd10, 16'd20, 16'd30, 4'd2, 16'd4000, 8'd1, 1'b0, EXP_MODEL);
		add_row(32'd1000, 32'd999, 16'd1, 16'd1, 16'd1, 4'd3, 16'd1, 8'd2, 1'b0, EXP_ORDER);
		add_row(32'd500, 32'd999, 16'd1, 16'd1, 16'd1, 4'd3, 16'd1, 8'd2, 1'b0, EXP_ORDER);
		// First gap includes the opening distance.
		add_row(32'd1500, 32'd700, 16'd900, 16'hFFFF, 16'd0, 4'd3, 16'd9000, 8'd5, 1'b0,
			EXP_MODEL);
		// Falling values, and a grid point landing exactly on the sample.
		add_row(32'd4000, 32'd300, 16'd0, 16'd0, 16'hFFFF, 4'd7, 16'd100, 8'd9, 1'b0, EXP_MODEL);
		add_row(32'd4500, 32'd5000, 16'hFFFF, 16'h8000, 16'h1, 4'hF, 16'hFFFF, 8'hAA, 1'b1,
			EXP_MODEL);
		// Gap too long for one run: truncated, then a last sample past the grid.
		add_row(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, 4'd1, 16'd0, 8'd0, 1'b0, EXP_MODEL);
		add_row(32'd200000, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 4'd2, 16'hFFFF, 8'h55, 1'b0,
			EXP_MODEL);
		add_row(32'd200500, 32'd77, 16'd5, 16'd6, 16'd7, 4'd8, 16'd9, 8'd10, 1'b1, EXP_MODEL);
		// Truncation on the last sample itself.
		add_row(32'd10, 32'd1, 16'd1, 16'd1, 16'd1, 4'd1, 16'd1, 8'd1, 1'b0, EXP_MODEL);
		add_row(32'd100010, 32'h8000_0000, 16'h8000, 16'h4000, 16'h2000, 4'h9, 16'h1234,
			8'h80, 1'b1, EXP_MODEL);
		// Backward sample with a last mark: the mark is ignored.
		add_row(32'd50, 32'd1, 16'd1, 16'd1, 16'd1, 4'd1, 16'd1, 8'd1, 1'b0, EXP_MODEL);
		add_row(32'd50, 32'd2, 16'd2, 16'd2, 16'd2, 4'd2, 16'd2, 8'd2, 1'b1, EXP_ORDER);
		add_row(32'd3050, 32'd3, 16'd3, 16'd3, 16'd3, 4'd3, 16'd3, 8'd3, 1'b1, EXP_MODEL);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_word(dir_tab[i].smp, dir_tab[i].kind);

		// Finest, coarsest, zero, random and reset spacing; quiet in the last phase.
		phase_step = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535)), STEP_RESET};
		foreach (phase_step[ph]) begin
			write_step(phase_step[ph]);
			if (ph == 0) pressure_req = 1;
			if (ph == 4) quiet = 1;
			random_streams(60);
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
